FILE: rtl/klao_pkg.sv
// ----------------------------------------------------------------------------
// klao_pkg
// Shared types, codes and constant tables of the ladder operator accumulator.
// ----------------------------------------------------------------------------
package klao_pkg;

    localparam int unsigned MAX_DIM_DEF   = 64;
    localparam int unsigned FRAC_BITS_DEF = 16;

    localparam int unsigned SIZE_W  = 7;   // before-size, level count, total size
    localparam int unsigned POS_W   = 6;   // projector position, read row/col
    localparam int unsigned DATA_W  = 32;  // Q-format entry width
    localparam int unsigned CALC_W  = 16;  // strides, block sizes, indexes
    localparam int unsigned TAB_N   = 1 << SIZE_W;

    typedef enum logic [1:0] {
        OP_ADD_SINGLE = 2'd0,
        OP_ADD_PAIR   = 2'd1,
        OP_READ       = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_LOWER  = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_RAISE  = 2'd2,
        KIND_PROJ   = 2'd3
    } t_kind;

    // one nonzero element of a small operator
    typedef struct packed {
        logic              ok;
        logic [SIZE_W-1:0] row;
        logic [SIZE_W-1:0] col;
        logic [DATA_W-1:0] val;
    } t_elem;

    typedef logic [DATA_W-1:0] t_sqrt_tab [TAB_N];

    // round(sqrt(n << 2*frac)), evaluated at elaboration only
    function automatic t_sqrt_tab make_sqrt_tab(input int unsigned frac);
        t_sqrt_tab   tab;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        for (int n = 0; n < TAB_N; n++) begin
            x = 64'(n) << (2 * frac);
            r = '0;
            for (int s = 31; s >= 0; s--) begin
                b = 64'(1) << (2 * s);
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
            end
            if (x > r) begin
                r = r + 64'd1;
            end
            tab[n] = r[DATA_W-1:0];
        end
        return tab;
    endfunction

    // number of loop steps of one operator
    function automatic logic [SIZE_W-1:0] loop_cnt(input t_kind kind,
                                                   input logic [SIZE_W-1:0] lev);
        logic [SIZE_W-1:0] n;
        case (kind)
            KIND_NUMBER: n = lev;
            KIND_PROJ:   n = SIZE_W'(1);
            default:     n = lev - SIZE_W'(1);
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/kron_ladder_operator_accumulator.sv
// ----------------------------------------------------------------------------
// kron_ladder_operator_accumulator
// Dense Q-format matrix accumulator for Kronecker-expanded ladder operators.
// ----------------------------------------------------------------------------
// Keeps a MAX_DIM x MAX_DIM matrix of signed fixed-point entries in one
// internal memory (one write, one registered read per cycle). After reset
// the block sweeps the memory to zero, one entry per cycle; s_axis_tready
// stays low meanwhile, the config channel is taken at any time. The block
// works on one transaction at a time: s_axis_tready is high only when the
// sequencer is idle. A read item waits in its read-wait step until the
// result register is free. An add item first works out its sizes: a
// handful of products on the shared multiplier, a 7-step division for the
// after-size and, for a pair, another 7-step division for the pair gap.
// It then walks every produced entry: each element of the first operator
// gets its scaled value and row and column offsets, each produced entry its
// row, column, value, memory read and write-back, and one more step closes
// each inner loop or skips an element that adds nothing; the multiplier and
// the read-modify-write of the memory are the shared resources. All products
// (index strides, coefficient times value) go through the one 32x32
// multiplier, registered, followed by a registered round/saturate stage.
// Entries outside total_size are dropped; sums saturate to 32 bits.
// ----------------------------------------------------------------------------
module kron_ladder_operator_accumulator #(
    parameter int unsigned MAX_DIM   = klao_pkg::MAX_DIM_DEF,
    parameter int unsigned FRAC_BITS = klao_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: total_size
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,    // [6:0] total_size
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] scale, [38:32] first_before, [45:39] first_levels,
    // [47:46] first_kind, [53:48] first_position, [60:54] second_before,
    // [67:61] second_levels, [69:68] second_kind, [75:70] second_position,
    // [81:76] read_row, [87:82] read_col
    input  logic [87:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,  // [1:0] operation
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [31:0] entry_value
);
    import klao_pkg::*;

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam t_sqrt_tab   SQRT_TAB = make_sqrt_tab(FRAC_BITS);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_RDW,
        S_P1, S_P1W, S_DIV_NB, S_NBW, S_M, S_MW, S_BW, S_DW, S_DIV_NA, S_NAW,
        S_SW, S_I, S_IT, S_IR, S_IC,
        S_E, S_ER, S_EC, S_EV, S_EA, S_EW
    } t_state;

    // ---- input field split ----
    t_op               in_op;
    logic [DATA_W-1:0] in_scale;
    logic [SIZE_W-1:0] in_fb, in_fl, in_sb, in_sl;
    logic [1:0]        in_fk, in_sk;
    logic [POS_W-1:0]  in_fp, in_sp, in_rr, in_rc;

    assign in_op    = t_op'(s_axis_tuser);
    assign in_scale = s_axis_tdata[31:0];
    assign in_fb    = s_axis_tdata[38:32];
    assign in_fl    = s_axis_tdata[45:39];
    assign in_fk    = s_axis_tdata[47:46];
    assign in_fp    = s_axis_tdata[53:48];
    assign in_sb    = s_axis_tdata[60:54];
    assign in_sl    = s_axis_tdata[67:61];
    assign in_sk    = s_axis_tdata[69:68];
    assign in_sp    = s_axis_tdata[75:70];
    assign in_rr    = s_axis_tdata[81:76];
    assign in_rc    = s_axis_tdata[87:82];

    // ---- registers ----
    t_state             r_state;
    logic [SIZE_W-1:0]  r_total;
    logic [AW-1:0]      r_clr;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_rd_zero;

    logic               r_pair;
    logic signed [DATA_W-1:0] r_scale;
    logic [SIZE_W-1:0]  r_b1, r_l1, r_b2, r_l2;
    t_kind              r_kind1, r_kind2;
    logic [POS_W-1:0]   r_pos1, r_pos2;

    logic [CALC_W-1:0]  r_nb, r_m, r_blk, r_na, r_s;
    logic [CALC_W-1:0]  r_rem, r_den;
    logic [SIZE_W-1:0]  r_dq;
    logic [2:0]         r_dcnt;

    logic [SIZE_W-1:0]  r_ka, r_kb, r_kc, r_i, r_j;
    logic [CALC_W-1:0]  r_bacc, r_kcl2, r_r1, r_c1, r_row, r_col;
    logic [DATA_W-1:0]  r_t, r_tv;
    logic [AW-1:0]      r_addr;
    logic               r_inr;

    logic signed [63:0] r_prod;
    logic [DATA_W-1:0]  r_mem_q;
    logic [DATA_W-1:0]  mem [DEPTH];

    // ---- helpers ----
    function automatic logic [DATA_W-1:0] fx_round(input logic signed [63:0] p);
        logic        neg;
        logic [63:0] m;
        logic [63:0] q;
        logic [DATA_W-1:0] res;
        neg = p[63];
        m   = neg ? 64'(-p) : 64'(p);
        q   = (m + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (!neg) begin
            res = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            res = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
        end
        return res;
    endfunction

    function automatic t_elem op_elem(input t_kind kind, input logic [SIZE_W-1:0] k,
                                      input logic [POS_W-1:0] pos,
                                      input logic [SIZE_W-1:0] lev);
        t_elem e;
        e.ok  = 1'b1;
        e.row = k;
        e.col = k;
        e.val = '0;
        case (kind)
            KIND_LOWER: begin
                e.col = k + SIZE_W'(1);
                e.val = SQRT_TAB[k + SIZE_W'(1)];
            end
            KIND_NUMBER: e.val = DATA_W'(k) << FRAC_BITS;
            KIND_RAISE: begin
                e.row = k + SIZE_W'(1);
                e.val = SQRT_TAB[k + SIZE_W'(1)];
            end
            KIND_PROJ: begin
                e.ok  = SIZE_W'(pos) < lev;
                e.row = SIZE_W'(pos);
                e.col = SIZE_W'(pos);
                e.val = DATA_W'(1) << FRAC_BITS;
            end
            default: e.ok = 1'b0;
        endcase
        return e;
    endfunction

    // ---- element decode ----
    t_elem             el1, el2;
    logic [SIZE_W-1:0] cnt1, cnt2;
    logic [CALC_W-1:0] base, rp, cp;

    always_comb begin
        el1  = op_elem(r_kind1, r_i, r_pos1, r_l1);
        cnt1 = loop_cnt(r_kind1, r_l1);
        if (r_pair) begin
            el2  = op_elem(r_kind2, r_j, r_pos2, r_l2);
            cnt2 = loop_cnt(r_kind2, r_l2);
        end else begin
            // single term: second factor is a 1-level identity
            el2  = '{ok: 1'b1, row: '0, col: '0, val: '0};
            cnt2 = SIZE_W'(1);
        end
    end

    assign base = CALC_W'(r_ka) + r_bacc;
    assign rp   = r_r1 + CALC_W'(el2.row) + r_kcl2;
    assign cp   = r_c1 + CALC_W'(el2.col) + r_kcl2;

    // ---- shared multiplier operand select ----
    logic signed [DATA_W-1:0] mul_a, mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_P1:  begin mul_a = 32'(r_b1);         mul_b = 32'(r_l1);         end
            S_M:   begin mul_a = 32'(r_l2);         mul_b = 32'(r_nb);         end
            S_MW:  begin mul_a = 32'(r_l1);         mul_b = 32'(r_prod[15:0]); end
            S_BW:  begin mul_a = 32'(r_b1);         mul_b = 32'(r_prod[15:0]); end
            S_NAW: begin mul_a = 32'(r_blk);        mul_b = 32'(r_dq);         end
            S_I:   begin mul_a = r_scale;           mul_b = el1.val;           end
            S_IT:  begin mul_a = 32'(r_m);          mul_b = 32'(el1.row);      end
            S_IR:  begin mul_a = 32'(r_m);          mul_b = 32'(el1.col);      end
            S_E:   begin mul_a = 32'(rp);           mul_b = 32'(r_na);         end
            S_ER:  begin mul_a = 32'(cp);           mul_b = 32'(r_na);         end
            S_EC:  begin mul_a = r_t;               mul_b = el2.val;           end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ---- divider step (restoring, one quotient bit per cycle) ----
    logic [CALC_W:0]   div_sh;
    logic              div_bit;
    logic [CALC_W-1:0] div_rem;

    always_comb begin
        div_sh  = {r_rem, r_dq[SIZE_W-1]};
        div_bit = div_sh >= {1'b0, r_den};
        div_rem = div_bit ? CALC_W'(div_sh - {1'b0, r_den}) : div_sh[CALC_W-1:0];
    end

    // ---- accumulate ----
    logic signed [DATA_W:0] acc_sum;
    logic [DATA_W-1:0]      acc_sat;
    logic [31:0]            ent_addr;
    logic                   ent_inr;
    logic [31:0]            rd_addr;

    always_comb begin
        acc_sum = $signed({r_mem_q[DATA_W-1], r_mem_q}) + $signed({r_tv[DATA_W-1], r_tv});
        if (acc_sum[DATA_W] != acc_sum[DATA_W-1]) begin
            acc_sat = acc_sum[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            acc_sat = acc_sum[DATA_W-1:0];
        end
        ent_addr = 32'(r_row) * 32'(MAX_DIM) + 32'(r_col);
        ent_inr  = (r_row < CALC_W'(r_total)) && (r_col < CALC_W'(r_total)) &&
                   (32'(r_row) < 32'(MAX_DIM)) && (32'(r_col) < 32'(MAX_DIM));
        rd_addr  = 32'(in_rr) * 32'(MAX_DIM) + 32'(in_rc);
    end

    // ---- memory ----
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [DATA_W-1:0] mem_wd;

    assign mem_we = (r_state == S_CLEAR) || ((r_state == S_EW) && r_inr);
    assign mem_wa = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign mem_wd = (r_state == S_CLEAR) ? '0 : acc_sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= mem[r_addr];
    end

    // ---- ports ----
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    logic in_acc;
    logic in_zero;
    logic in_swap;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_swap = (in_op == OP_ADD_PAIR) && (in_sb < in_fb);
    assign in_zero = (in_fb == '0) || (in_fl == '0) ||
                     ((in_op == OP_ADD_PAIR) && ((in_sb == '0) || (in_sl == '0)));

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_total     <= SIZE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_total <= i_cfg_data;
            end
            // the read-wait step handles the result register itself
            if (r_out_valid && m_axis_tready && (r_state != S_RDW)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_pair  <= (in_op == OP_ADD_PAIR);
                        r_scale <= in_scale;
                        if (in_swap) begin
                            r_b1 <= in_sb; r_l1 <= in_sl;
                            r_kind1 <= t_kind'(in_sk); r_pos1 <= in_sp;
                            r_b2 <= in_fb; r_l2 <= in_fl;
                            r_kind2 <= t_kind'(in_fk); r_pos2 <= in_fp;
                        end else begin
                            r_b1 <= in_fb; r_l1 <= in_fl;
                            r_kind1 <= t_kind'(in_fk); r_pos1 <= in_fp;
                            r_b2 <= in_sb;
                            r_l2 <= (in_op == OP_ADD_PAIR) ? in_sl : SIZE_W'(1);
                            r_kind2 <= t_kind'(in_sk); r_pos2 <= in_sp;
                        end
                        r_addr    <= rd_addr[AW-1:0];
                        r_rd_zero <= (32'(in_rr) >= 32'(MAX_DIM)) ||
                                     (32'(in_rc) >= 32'(MAX_DIM));
                        case (in_op)
                            OP_ADD_SINGLE, OP_ADD_PAIR: begin
                                if (!in_zero) begin
                                    r_state <= S_P1;
                                end
                            end
                            OP_READ: r_state <= S_RD;
                            default: ;
                        endcase
                    end
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_rd_zero ? '0 : r_mem_q;
                        r_state     <= S_IDLE;
                    end
                end
                S_P1: r_state <= S_P1W;
                S_P1W: begin
                    if (r_pair) begin
                        // pair gap: before2 / (before1 * levels1)
                        r_dq    <= r_b2;
                        r_rem   <= '0;
                        r_den   <= r_prod[CALC_W-1:0];
                        r_dcnt  <= '0;
                        r_state <= S_DIV_NB;
                    end else begin
                        r_nb    <= CALC_W'(1);
                        r_state <= S_M;
                    end
                end
                S_DIV_NB, S_DIV_NA: begin
                    r_rem  <= div_rem;
                    r_dq   <= {r_dq[SIZE_W-2:0], div_bit};
                    r_dcnt <= r_dcnt + 3'd1;
                    if (r_dcnt == 3'(SIZE_W - 1)) begin
                        r_state <= (r_state == S_DIV_NB) ? S_NBW : S_NAW;
                    end
                end
                S_NBW: begin
                    r_nb    <= CALC_W'(r_dq);
                    r_state <= (r_dq == '0) ? S_IDLE : S_M;
                end
                S_M:  r_state <= S_MW;
                S_MW: begin
                    r_m     <= r_prod[CALC_W-1:0];
                    r_state <= S_BW;
                end
                S_BW: begin
                    r_blk   <= r_prod[CALC_W-1:0];
                    r_state <= S_DW;
                end
                S_DW: begin
                    // after-size: total / (block * before1)
                    r_dq    <= r_total;
                    r_rem   <= '0;
                    r_den   <= r_prod[CALC_W-1:0];
                    r_dcnt  <= '0;
                    r_state <= S_DIV_NA;
                end
                S_NAW: begin
                    r_na    <= CALC_W'(r_dq);
                    r_state <= (r_dq == '0) ? S_IDLE : S_SW;
                end
                S_SW: begin
                    r_s     <= r_prod[CALC_W-1:0];
                    r_ka    <= '0;
                    r_kb    <= '0;
                    r_i     <= '0;
                    r_bacc  <= '0;
                    r_state <= S_I;
                end
                S_I: begin
                    if (r_i >= cnt1) begin
                        r_i <= '0;
                        if ((SIZE_W + 1)'(r_kb) + 1'b1 < (SIZE_W + 1)'(r_b1)) begin
                            r_kb   <= r_kb + SIZE_W'(1);
                            r_bacc <= r_bacc + r_s;
                        end else begin
                            r_kb   <= '0;
                            r_bacc <= '0;
                            if ((CALC_W + 1)'(r_ka) + 1'b1 < (CALC_W + 1)'(r_na)) begin
                                r_ka <= r_ka + SIZE_W'(1);
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else if (!el1.ok) begin
                        r_i <= r_i + SIZE_W'(1);
                    end else begin
                        r_state <= S_IT;
                    end
                end
                S_IT: begin
                    r_t     <= fx_round(r_prod);
                    r_state <= S_IR;
                end
                S_IR: begin
                    r_r1    <= r_prod[CALC_W-1:0];
                    r_state <= S_IC;
                end
                S_IC: begin
                    r_c1    <= r_prod[CALC_W-1:0];
                    r_kc    <= '0;
                    r_j     <= '0;
                    r_kcl2  <= '0;
                    r_state <= S_E;
                end
                S_E: begin
                    if (r_j >= cnt2) begin
                        r_j <= '0;
                        if ((CALC_W + 1)'(r_kc) + 1'b1 < (CALC_W + 1)'(r_nb)) begin
                            r_kc   <= r_kc + SIZE_W'(1);
                            r_kcl2 <= r_kcl2 + CALC_W'(r_l2);
                        end else begin
                            r_i     <= r_i + SIZE_W'(1);
                            r_state <= S_I;
                        end
                    end else if (!el2.ok) begin
                        r_j <= r_j + SIZE_W'(1);
                    end else begin
                        r_state <= S_ER;
                    end
                end
                S_ER: begin
                    r_row   <= r_prod[CALC_W-1:0] + base;
                    r_state <= S_EC;
                end
                S_EC: begin
                    r_col   <= r_prod[CALC_W-1:0] + base;
                    r_state <= S_EV;
                end
                S_EV: begin
                    r_tv    <= r_pair ? fx_round(r_prod) : r_t;
                    r_addr  <= ent_addr[AW-1:0];
                    r_inr   <= ent_inr;
                    r_state <= S_EA;
                end
                S_EA: r_state <= S_EW;
                S_EW: begin
                    r_j     <= r_j + SIZE_W'(1);
                    r_state <= S_E;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // no matrix update outside the clear sweep and the write step
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_EW))
        else $error("matrix write outside clear or write step");

    // a result only appears after the read path
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_RDW))
        else $error("result without read item");

    // divisor of a division is never zero
    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_NB || r_state == S_DIV_NA) |-> (r_den != '0))
        else $error("division by zero size");

    // the clear sweep finishes before any item is taken
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("item taken during clear sweep");

    // a written entry was found in range
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EW && r_inr) |-> (r_row < CALC_W'(r_total)))
        else $error("write outside active size");
`endif

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Kronecker ladder operator accumulator.
// A matrix model mirrors every add transaction and predicts each read;
// results are compared in order while both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import klao_pkg::*;

    localparam int          DIM        = 64;
    localparam int          FRAC       = 16;
    localparam longint      ONE        = 64'sd1 << FRAC;
    localparam longint      CYCLE_CAP  = 12_000_000;

    typedef struct {
        t_op         op;
        logic [31:0] scale;
        logic [6:0]  fb, fl;
        t_kind       fk;
        logic [5:0]  fp;
        logic [6:0]  sb, sl;
        t_kind       sk;
        logic [5:0]  sp;
        logic [5:0]  rr, rc;
    } t_item;

    // ------------------------------------------------------------------------
    // matrix model: own copy of the store and size, queue of pending reads
    // ------------------------------------------------------------------------
    class matrix_model;
        int          entry [DIM*DIM];
        int unsigned dim_n;
        longint      root_tab [130];
        logic [31:0] pending_reads [$];
        int          errors;

        function new();
            longint x, lo, hi, mid;
            dim_n  = 1;
            errors = 0;
            foreach (entry[i]) entry[i] = 0;
            for (int n = 0; n < 130; n++) begin
                x  = longint'(n) << (2 * FRAC);
                lo = 0;
                hi = 64'd1 << 21;
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    if (mid * mid <= x) lo = mid;
                    else hi = mid;
                end
                // round to nearest: remainder above the root bumps it
                root_tab[n] = (x - lo * lo > lo) ? lo + 1 : lo;
            end
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint fmul(longint a, longint b);
            longint          p;
            longint unsigned m;
            p = a * b;
            m = (p < 0) ? longint'(-p) : p;
            m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
            if (m > (64'd1 << 32)) m = 64'd1 << 32;
            return sat((p < 0) ? -longint'(m) : longint'(m));
        endfunction

        function int unsigned steps(t_kind k, int unsigned lev);
            if (k == KIND_NUMBER) return lev;
            if (k == KIND_PROJ) return 1;
            return lev - 1;
        endfunction

        function bit elem(t_kind k, int unsigned i, int unsigned pos, int unsigned lev,
                          output int unsigned r, output int unsigned c, output longint v);
            r = i; c = i; v = 0;
            case (k)
                KIND_LOWER:  begin c = i + 1; v = root_tab[i+1]; end
                KIND_NUMBER: v = longint'(i) << FRAC;
                KIND_RAISE:  begin r = i + 1; v = root_tab[i+1]; end
                default: begin
                    if (pos >= lev) return 0;
                    r = pos; c = pos; v = ONE;
                end
            endcase
            return 1;
        endfunction

        function void accumulate(int unsigned r, int unsigned c, longint t);
            if (r >= dim_n || c >= dim_n || r >= DIM || c >= DIM) return;
            entry[r*DIM+c] = int'(sat(longint'(entry[r*DIM+c]) + t));
        endfunction

        function void expand_single(longint s, int unsigned b, int unsigned l,
                                    t_kind k, int unsigned p);
            int unsigned na, r, c;
            longint      v;
            if (b == 0 || l == 0) return;
            na = dim_n / (b * l);
            for (int unsigned k1 = 0; k1 < na; k1++)
                for (int unsigned k2 = 0; k2 < b; k2++)
                    for (int unsigned i = 0; i < steps(k, l); i++)
                        if (elem(k, i, p, l, r, c, v))
                            accumulate(r*na + k1 + k2*l*na, c*na + k1 + k2*l*na,
                                       fmul(s, v));
        endfunction

        function void expand_pair(longint s, int unsigned b1, int unsigned l1, t_kind t1,
                                  int unsigned p1, int unsigned b2, int unsigned l2,
                                  t_kind t2, int unsigned p2);
            int unsigned nb, blk, na, base, r1, c1, r2, c2, x;
            t_kind       tk;
            longint      v1, v2, t;
            if (b1 == 0 || l1 == 0 || b2 == 0 || l2 == 0) return;
            if (b2 < b1) begin
                // the whole operator description moves with its before-size
                x = b1; b1 = b2; b2 = x;
                x = l1; l1 = l2; l2 = x;
                x = p1; p1 = p2; p2 = x;
                tk = t1; t1 = t2; t2 = tk;
            end
            nb = b2 / (b1 * l1);
            if (nb == 0) return;
            blk = l1 * l2 * nb;
            na  = dim_n / (blk * b1);
            for (int unsigned k1 = 0; k1 < na; k1++)
                for (int unsigned k2 = 0; k2 < b1; k2++) begin
                    base = k1 + k2 * blk * na;
                    for (int unsigned i = 0; i < steps(t1, l1); i++) begin
                        if (!elem(t1, i, p1, l1, r1, c1, v1)) continue;
                        t = fmul(s, v1);
                        for (int unsigned k3 = 0; k3 < nb; k3++)
                            for (int unsigned j = 0; j < steps(t2, l2); j++)
                                if (elem(t2, j, p2, l2, r2, c2, v2))
                                    accumulate((l2*nb*r1 + r2 + k3*l2) * na + base,
                                               (l2*nb*c1 + c2 + k3*l2) * na + base,
                                               fmul(t, v2));
                    end
                end
        endfunction

        function void note_item(t_item it);
            longint s;
            s = longint'($signed(it.scale));
            case (it.op)
                OP_ADD_SINGLE: expand_single(s, it.fb, it.fl, it.fk, it.fp);
                OP_ADD_PAIR:   expand_pair(s, it.fb, it.fl, it.fk, it.fp,
                                           it.sb, it.sl, it.sk, it.sp);
                OP_READ:       pending_reads.push_back(entry[it.rr*DIM + it.rc]);
                default: ;
            endcase
        endfunction

        function void check_entry(logic [31:0] got);
            logic [31:0] want;
            if (pending_reads.size() == 0) begin
                $error("entry_value: unexpected result 0x%08h", got);
                errors++;
                return;
            end
            want = pending_reads.pop_front();
            if (got !== want) begin
                $error("entry_value: expected 0x%08h actual 0x%08h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    matrix_model model;
    bit          quiet;      // final stretch: no idling on either side
    int          rx_hold;
    longint      cycles;

    kron_ladder_operator_accumulator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog; also covers the post-reset clearing sweep
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: every accepted transaction is checked against the oldest read
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) model.check_entry(m_axis_tdata);
    end

    // result-side stalls in bursts of random length
    always @(negedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= (rx_hold == 0);
        end else if ($urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(1, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // only called with no transaction in flight
    task automatic write_size(input logic [6:0] n);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.dim_n = n;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drive one transaction; valid is left high when no gap follows
    task automatic send_item(input t_item it);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {it.rc, it.rr, it.sp, it.sk, it.sl, it.sb,
                          it.fp, it.fk, it.fl, it.fb, it.scale};
        do @(posedge i_clk); while (!s_axis_tready);
        model.note_item(it);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    // called right after a negedge: wait for every read to return and the
    // block to go idle, so a trailing add walk is finished
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (model.pending_reads.size() != 0 || !s_axis_tready) @(negedge i_clk);
    endtask

    function automatic t_item blank(t_op op);
        t_item it;
        it.op = op; it.scale = 32'(ONE);
        it.fb = 1; it.fl = 1; it.fk = KIND_NUMBER; it.fp = 0;
        it.sb = 1; it.sl = 1; it.sk = KIND_NUMBER; it.sp = 0;
        it.rr = 0; it.rc = 0;
        return it;
    endfunction

    function automatic t_item rd(int r, int c);
        t_item it;
        it = blank(OP_READ);
        it.rr = 6'(r); it.rc = 6'(c);
        return it;
    endfunction

    function automatic t_item one_op(t_kind k, int b, int l, int p, logic [31:0] s);
        t_item it;
        it = blank(OP_ADD_SINGLE);
        it.fk = k; it.fb = 7'(b); it.fl = 7'(l); it.fp = 6'(p); it.scale = s;
        return it;
    endfunction

    function automatic logic [31:0] rand_scale();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
    endfunction

    // sizes that mostly tile the space, with some full-range noise
    function automatic logic [6:0] rand_size();
        if ($urandom_range(0, 11) == 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(1, 6));
    endfunction

    function automatic t_item rand_item(int unsigned n);
        t_item it;
        int    pick;
        it = blank(OP_READ);
        pick = $urandom_range(0, 99);
        it.scale = rand_scale();
        it.fk = t_kind'($urandom_range(0, 3));
        it.sk = t_kind'($urandom_range(0, 3));
        if (pick < 40) begin
            it.op = OP_ADD_SINGLE;
            it.fb = rand_size();
            it.fl = rand_size();
        end else if (pick < 65) begin
            it.op = OP_ADD_PAIR;
            it.fb = 7'($urandom_range(1, 3));
            it.fl = 7'($urandom_range(1, 4));
            it.sl = 7'($urandom_range(1, 4));
            it.sb = 7'(it.fb * it.fl * $urandom_range(1, 2));
            if ($urandom_range(0, 5) == 0) begin
                it.fb = rand_size(); it.sb = rand_size();
            end
            if ($urandom_range(0, 1)) begin
                // swap the sizes of the two operators; kinds and positions stay
                {it.fb, it.sb} = {it.sb, it.fb};
                {it.fl, it.sl} = {it.sl, it.fl};
            end
        end else if (pick < 98) begin
            it.op = OP_READ;
            if (n > 0 && n <= DIM && $urandom_range(0, 3) != 0) begin
                it.rr = 6'($urandom_range(0, n - 1));
                it.rc = 6'($urandom_range(0, n - 1));
            end else begin
                it.rr = 6'($urandom);
                it.rc = 6'($urandom);
            end
        end else begin
            it.op = OP_NONE;
        end
        // projector position: mostly inside the operator, sometimes anywhere
        it.fp = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
        it.sp = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
        return it;
    endfunction

    initial begin
        logic [6:0] sizes [10];
        t_item      it;

        sizes = '{7'd12, 7'd1, 7'd36, 7'd0, 7'd48, 7'd127, 7'd16, 7'd24, 7'd64, 7'd32};
        model = new();
        quiet = 1'b0;
        rx_hold = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NONE;
        m_axis_tready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, full 64-entry space
        write_size(7'd64);
        send_item(rd(0, 0));
        send_item(rd(63, 63));
        send_item(one_op(KIND_LOWER, 1, 64, 0, 32'(ONE)));
        send_item(rd(0, 1));
        send_item(rd(62, 63));
        send_item(one_op(KIND_NUMBER, 1, 64, 0, 32'hFFFF_0000));
        send_item(rd(63, 63));
        send_item(one_op(KIND_RAISE, 2, 32, 0, 32'h7FFF_FFFF));
        send_item(rd(1, 0));
        send_item(one_op(KIND_PROJ, 8, 8, 5, 32'h8000_0000));
        // projector outside its levels adds nothing
        send_item(one_op(KIND_PROJ, 8, 8, 9, 32'h7FFF_FFFF));
        send_item(rd(5, 5));
        // zero sizes and an empty after-size drop the term
        send_item(one_op(KIND_NUMBER, 0, 4, 0, 32'(ONE)));
        send_item(one_op(KIND_NUMBER, 4, 0, 0, 32'(ONE)));
        send_item(one_op(KIND_NUMBER, 127, 1, 0, 32'(ONE)));
        // pair in reversed order, then a pair whose gap is empty
        it = blank(OP_ADD_PAIR);
        it.fb = 4; it.fl = 4; it.fk = KIND_RAISE; it.fp = 3;
        it.sb = 2; it.sl = 2; it.sk = KIND_PROJ;  it.sp = 1;
        it.scale = 32'h0003_8000;
        send_item(it);
        it.fb = 2; it.fl = 8; it.sb = 4; it.sk = KIND_LOWER;
        send_item(it);
        send_item(rd(9, 8));
        it = blank(OP_NONE);
        send_item(it);
        // drive entries into saturation both ways
        send_item(one_op(KIND_NUMBER, 1, 64, 0, 32'h7FFF_FFFF));
        send_item(one_op(KIND_NUMBER, 1, 64, 0, 32'h7FFF_FFFF));
        send_item(rd(40, 40));
        send_item(one_op(KIND_NUMBER, 1, 64, 0, 32'h8000_0000));
        send_item(one_op(KIND_NUMBER, 1, 64, 0, 32'h8000_0000));
        send_item(rd(40, 40));

        // random phases, each at its own space size; the sender drains in between
        foreach (sizes[ph]) begin
            drain();
            write_size(sizes[ph]);
            quiet = (ph == 9);
            repeat (180) send_item(rand_item(sizes[ph]));
        end

        drain();
        if (model.errors == 0 && model.pending_reads.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
